// ===== design/lsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Lid switch debouncer package
// Shared types, register indexes and constants of the sampled debouncer.
// ----------------------------------------------------------------------------
package lsd_pkg;

  localparam int TIME_BITS_DEF = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [15:0] MIN_WINDOW = 16'd50;
  localparam logic [15:0] DEF_INTERVAL = 16'd10;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLED = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FORCED_MODE = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_MS = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INTERVAL_MS = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_LEVEL = 3'd4;

  typedef enum logic [1:0] {
    FORCE_NONE = 2'd0,
    FORCE_LOW  = 2'd1,
    FORCE_HIGH = 2'd2
  } forced_mode_t;

  typedef struct packed {
    logic        enabled;
    logic [1:0]  forced_mode;
    logic [15:0] window_ms;
    logic [15:0] interval_ms;
    logic        active_level;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic lid_closed;
    logic was_forced;
  } res_t;

endpackage

// ===== design/lsd_window.sv =====
// ----------------------------------------------------------------------------
// Lid switch debouncer check window
// Per-tick window state: start, sampling, agreement check and report.
// ----------------------------------------------------------------------------
module lsd_window
  import lsd_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic pin_level,
  input  logic edge_seen,
  input  cfg_t cfg,
  output res_t res
);

  localparam int WB = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
  localparam logic [WB-1:0] TMAX_W = WB'(TMAX);

  logic                 busy;
  logic                 pending;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] icount;
  logic [TIME_BITS-1:0] eff_window;
  logic [TIME_BITS-1:0] eff_interval;
  logic                 any_match;
  logic                 any_miss;
  logic                 pin_status;
  logic                 saved_status;

  logic [TIME_BITS-1:0] elapsed_next;
  logic [TIME_BITS-1:0] icount_next;
  logic                 sample;
  logic                 hit;
  logic                 any_match_next;
  logic                 any_miss_next;
  logic                 end_win;
  logic                 mixed;
  logic                 start;
  logic                 forced;
  logic [15:0]          wclamp;
  logic [15:0]          iclamp;
  logic [WB-1:0]        wclamp_w;
  logic [WB-1:0]        iclamp_w;
  logic [TIME_BITS-1:0] win_sat;
  logic [TIME_BITS-1:0] int_sat;

  always_comb begin
    elapsed_next   = (elapsed == TMAX) ? elapsed : elapsed + 1'b1;
    icount_next    = (icount == TMAX) ? icount : icount + 1'b1;
    sample         = icount_next >= eff_interval;
    hit            = pin_level == cfg.active_level;
    any_match_next = any_match | hit;
    any_miss_next  = any_miss | ~hit;
    end_win        = sample &&
                     (({1'b0, elapsed_next} + {1'b0, eff_interval}) > {1'b0, eff_window});
    mixed          = any_match_next && any_miss_next;
    start          = edge_seen || pending;
    forced         = (cfg.forced_mode == FORCE_LOW) || (cfg.forced_mode == FORCE_HIGH);
    wclamp         = (cfg.window_ms < MIN_WINDOW) ? MIN_WINDOW : cfg.window_ms;
    iclamp         = ((cfg.interval_ms < DEF_INTERVAL) || (cfg.interval_ms > cfg.window_ms))
                     ? DEF_INTERVAL : cfg.interval_ms;
    wclamp_w       = WB'(wclamp);
    iclamp_w       = WB'(iclamp);
    win_sat        = (wclamp_w > TMAX_W) ? TMAX : wclamp_w[TIME_BITS-1:0];
    int_sat        = (iclamp_w > TMAX_W) ? TMAX : iclamp_w[TIME_BITS-1:0];
  end

  always_comb begin
    res = '0;
    if (step) begin
      if (busy) begin
        if (sample && end_win && !mixed) begin
          res.valid      = 1'b1;
          res.lid_closed = hit;
        end
      end else if (start && forced) begin
        res.valid      = 1'b1;
        res.lid_closed = cfg.forced_mode == FORCE_HIGH;
        res.was_forced = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pending      <= 1'b1;
      elapsed      <= '0;
      icount       <= '0;
      eff_window   <= '0;
      eff_interval <= '0;
      any_match    <= 1'b0;
      any_miss     <= 1'b0;
      pin_status   <= 1'b0;
      saved_status <= 1'b0;
    end else if (step) begin
      if (busy) begin
        if (edge_seen) begin
          pending <= 1'b1;
        end
        elapsed <= elapsed_next;
        if (sample) begin
          icount    <= '0;
          any_match <= any_match_next;
          any_miss  <= any_miss_next;
          if (end_win) begin
            busy       <= 1'b0;
            pin_status <= mixed ? saved_status : ~hit;
          end else begin
            pin_status <= ~hit;
          end
        end else begin
          icount <= icount_next;
        end
      end else if (start) begin
        pending <= 1'b0;
        if (!forced) begin
          eff_window   <= win_sat;
          eff_interval <= int_sat;
          if (cfg.enabled) begin
            saved_status <= pin_status;
            elapsed      <= '0;
            icount       <= '0;
            any_match    <= 1'b0;
            any_miss     <= 1'b0;
            busy         <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== design/lid_switch_sample_debouncer_core.sv =====
// ----------------------------------------------------------------------------
// Lid switch sampled debouncer
// Debounces a lid sensor pin over a sampled check window, one tick per request.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid/in_ready    | pin_level, edge_seen
//   out     | out       | out_valid/out_ready  | lid_closed, was_forced
//
// Each tick request is taken when in_valid and in_ready are both high; its result,
// if any, is registered into the output register, or into a skid stage behind it
// while the output register is stalled. The skid stage keeps in_ready high while
// one result is stalled; in_ready drops only when both hold results. Reset queues
// one initial check window; cfg_ready is always high.
// ----------------------------------------------------------------------------
module lid_switch_sample_debouncer_core
  import lsd_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      pin_level,
  input  logic                      edge_seen,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      lid_closed,
  output logic                      was_forced
);

  cfg_t cfg;
  res_t res;
  logic step;
  logic skid_valid;
  logic skid_lid;
  logic skid_forced;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~skid_valid;
  assign step      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled      <= 1'b1;
      cfg.forced_mode  <= FORCE_NONE;
      cfg.window_ms    <= 16'd60;
      cfg.interval_ms  <= 16'd30;
      cfg.active_level <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLED:      cfg.enabled      <= cfg_data[0];
        REG_FORCED_MODE:  cfg.forced_mode  <= cfg_data[1:0];
        REG_WINDOW_MS:    cfg.window_ms    <= cfg_data[15:0];
        REG_INTERVAL_MS:  cfg.interval_ms  <= cfg_data[15:0];
        REG_ACTIVE_LEVEL: cfg.active_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lsd_window #(
    .TIME_BITS(TIME_BITS)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .pin_level(pin_level),
    .edge_seen(edge_seen),
    .cfg      (cfg),
    .res      (res)
  );

  // advance the output register from the skid stage first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= res.valid;
      end else begin
        out_valid <= res.valid;
      end
    end else if (res.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        lid_closed  <= skid_lid;
        was_forced  <= skid_forced;
        skid_lid    <= res.lid_closed;
        skid_forced <= res.was_forced;
      end else begin
        lid_closed <= res.lid_closed;
        was_forced <= res.was_forced;
      end
    end else if (res.valid) begin
      skid_lid    <= res.lid_closed;
      skid_forced <= res.was_forced;
    end
  end

  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output register is empty");

  a_result_on_accept : assert property (@(posedge clk) disable iff (rst)
    res.valid |-> step)
    else $error("result produced without an accepted request");

  a_stall_to_skid : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && res.valid) |=> skid_valid)
    else $error("result dropped while the output register was stalled");

endmodule

// ===== verif/tb_lid_switch_sample_debouncer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lid switch sampled debouncer testbench
// Streams millisecond tick requests into the debouncer, tracks the window,
// sampling and forced-mode behaviour in a local model, and checks every lid
// report in order. Registers are rewritten between bursts; sender and receiver
// idle at random in three phases.
// ----------------------------------------------------------------------------
module tb_lid_switch_sample_debouncer_core;
  import lsd_pkg::*;

  localparam int TW = TIME_BITS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_TICKS = 480;

  typedef struct packed {
    logic pin;
    logic edge_flag;
  } tick_t;

  typedef struct packed {
    logic lid_closed;
    logic was_forced;
  } lid_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic pin_level = 1'b0;
  logic edge_seen = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic lid_closed;
  logic was_forced;

  tick_t tick_q[$];
  lid_report_t lid_reports_q[$];
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int cycle_count = 0;

  // model copy of the registers
  logic cfg_enabled = 1'b1;
  logic [1:0] cfg_forced = FORCE_NONE;
  logic [15:0] cfg_window = 16'd60;
  logic [15:0] cfg_interval = 16'd30;
  logic cfg_active = 1'b0;

  // model copy of the window state
  logic win_busy = 1'b0;
  logic win_pending = 1'b1;
  logic [TW-1:0] elapsed = '0;
  logic [TW-1:0] ivl_count = '0;
  logic [TW-1:0] win_length = '0;
  logic [TW-1:0] win_interval = '0;
  logic [TW-1:0] samples = '0;
  logic [TW-1:0] match_cnt = '0;
  logic pin_stat = 1'b0;
  logic saved_stat = 1'b0;

  lid_switch_sample_debouncer_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pin_level  (pin_level),
    .edge_seen  (edge_seen),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .lid_closed (lid_closed),
    .was_forced (was_forced)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
    return (v == {TW{1'b1}}) ? v : v + 1'b1;
  endfunction

  task automatic apply_reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                 input logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      REG_ENABLED:      cfg_enabled = val[0];
      REG_FORCED_MODE:  cfg_forced = val[1:0];
      REG_WINDOW_MS:    cfg_window = val;
      REG_INTERVAL_MS:  cfg_interval = val;
      REG_ACTIVE_LEVEL: cfg_active = val[0];
      default: ;
    endcase
  endtask

  task automatic debounce_tick(input logic pin, input logic edge_in,
                               output bit produced, output lid_report_t rep);
    logic [TW:0] reach;
    produced = 1'b0;
    rep = '0;
    if (win_busy) begin
      if (edge_in) win_pending = 1'b1;
      elapsed = sat_inc(elapsed);
      ivl_count = sat_inc(ivl_count);
      if (ivl_count >= win_interval) begin
        ivl_count = '0;
        samples = sat_inc(samples);
        if (pin == cfg_active) begin
          pin_stat = 1'b0;
          match_cnt = sat_inc(match_cnt);
        end else begin
          pin_stat = 1'b1;
        end
        reach = {1'b0, elapsed} + {1'b0, win_interval};
        if (reach > {1'b0, win_length}) begin
          win_busy = 1'b0;
          if (match_cnt != '0 && match_cnt < samples) begin
            pin_stat = saved_stat;
          end else begin
            produced = 1'b1;
            rep.lid_closed = ~pin_stat;
            rep.was_forced = 1'b0;
          end
        end
      end
    end else if (edge_in || win_pending) begin
      win_pending = 1'b0;
      if (cfg_forced == FORCE_LOW || cfg_forced == FORCE_HIGH) begin
        produced = 1'b1;
        rep.lid_closed = (cfg_forced == FORCE_HIGH);
        rep.was_forced = 1'b1;
      end else begin
        win_length = (cfg_window < MIN_WINDOW) ? MIN_WINDOW : cfg_window;
        win_interval = (cfg_interval < DEF_INTERVAL || cfg_interval > cfg_window) ?
                       DEF_INTERVAL : cfg_interval;
        if (cfg_enabled) begin
          saved_stat = pin_stat;
          elapsed = '0;
          ivl_count = '0;
          samples = '0;
          match_cnt = '0;
          win_busy = 1'b1;
        end
      end
    end
  endtask

  // driver: hold each request until it is taken
  always @(posedge clk) begin
    tick_t nxt;
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      offer = (tick_q.size() != 0) && ($urandom_range(99) >= sender_idle_pct);
      if (offer) begin
        nxt = tick_q.pop_front();
        pin_level <= nxt.pin;
        edge_seen <= nxt.edge_flag;
      end
      in_valid <= offer;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: advance the model on each request, check each report
  always @(posedge clk) begin
    lid_report_t want;
    lid_report_t got;
    bit produced;
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        debounce_tick(pin_level, edge_seen, produced, want);
        if (produced) lid_reports_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        got.lid_closed = lid_closed;
        got.was_forced = was_forced;
        if (lid_reports_q.size() == 0) begin
          $error("unexpected report: lid_closed %0b, was_forced %0b",
                 got.lid_closed, got.was_forced);
          err_count++;
        end else begin
          want = lid_reports_q.pop_front();
          if (got.lid_closed !== want.lid_closed) begin
            $error("lid_closed: expected %0b, actual %0b", want.lid_closed, got.lid_closed);
            err_count++;
          end
          if (got.was_forced !== want.was_forced) begin
            $error("was_forced: expected %0b, actual %0b", want.was_forced, got.was_forced);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_tick(input logic pin, input logic edge_in);
    tick_t t;
    t.pin = pin;
    t.edge_flag = edge_in;
    tick_q.push_back(t);
  endtask

  // bounce for a few ticks, then settle on one level
  task automatic push_settle(input int bounce, input logic level, input int hold);
    for (int k = 0; k < bounce; k++) push_tick(1'($urandom), $urandom_range(3) != 0);
    for (int k = 0; k < hold; k++) push_tick(level, (k == 0) || ($urandom_range(39) == 0));
  endtask

  task automatic push_noise(input int n);
    for (int k = 0; k < n; k++) push_tick(1'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || lid_reports_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic shuffle_cfg();
    logic [15:0] win;
    logic [15:0] ivl;
    logic [1:0] mode;
    case ($urandom_range(7))
      0: win = 16'd0;
      1: win = MIN_WINDOW - 16'd1;
      2: win = MIN_WINDOW;
      3: win = MIN_WINDOW + 16'd1;
      default: win = 16'($urandom_range(40, 150));
    endcase
    case ($urandom_range(7))
      0: ivl = 16'd0;
      1: ivl = DEF_INTERVAL - 16'd1;
      2: ivl = DEF_INTERVAL;
      3: ivl = win;
      4: ivl = win + 16'd1;
      5: ivl = 16'hFFFF;
      default: ivl = 16'($urandom_range(5, 60));
    endcase
    case ($urandom_range(9))
      7: mode = FORCE_LOW;
      8: mode = FORCE_HIGH;
      9: mode = 2'd3;
      default: mode = FORCE_NONE;
    endcase
    write_reg(REG_WINDOW_MS, win);
    write_reg(REG_INTERVAL_MS, ivl);
    write_reg(REG_FORCED_MODE, {14'($urandom), mode});
    write_reg(REG_ENABLED, {15'($urandom), 1'($urandom_range(9) != 0)});
    write_reg(REG_ACTIVE_LEVEL, {15'($urandom), 1'($urandom)});
  endtask

  initial begin
    int k;
    int seg;
    int phase_ticks;
    int n;

    sender_idle_pct = 29;
    recv_stall_pct = 82;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset window with default registers, edge while busy and on the last tick
    for (k = 0; k < 62; k++) push_tick(1'b1, (k == 5) || (k == 60));
    for (k = 0; k < 62; k++) push_tick(1'b0, 1'b0);
    wait_drained();

    write_reg(REG_ENABLED, 16'hFFFE);
    push_tick(1'b0, 1'b1);
    write_reg(REG_FORCED_MODE, 16'hFFFD);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    wait_drained();
    write_reg(REG_FORCED_MODE, {14'd0, FORCE_HIGH});
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    wait_drained();
    write_reg(REG_FORCED_MODE, 16'h0003);
    push_tick(1'b1, 1'b1);
    wait_drained();
    write_reg(REG_WINDOW_MS, 16'hFFFF);
    write_reg(REG_INTERVAL_MS, 16'hFFFF);
    push_tick(1'b0, 1'b1);
    wait_drained();
    for (k = 1; k <= 3; k++) write_reg(REG_ACTIVE_LEVEL + 3'(k), 16'hFFFF);
    write_reg(REG_WINDOW_MS, 16'd0);
    write_reg(REG_INTERVAL_MS, 16'd0);
    write_reg(REG_ACTIVE_LEVEL, 16'hFFFF);
    write_reg(REG_ENABLED, 16'h0001);
    push_tick(1'b1, 1'b1);
    for (k = 1; k <= 50; k++) push_tick(1'b1, 1'b0);
    // mixed samples restore the earlier status
    push_tick(1'b1, 1'b1);
    for (k = 1; k <= 52; k++) push_tick(k != 20, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 29; recv_stall_pct = 82; end
        1: begin sender_idle_pct = 82; recv_stall_pct = 29; end
        default: begin sender_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      phase_ticks = 0;
      seg = 0;
      while (phase_ticks < PHASE_TICKS) begin
        if (seg % 4 == 0) begin
          wait_drained();
          shuffle_cfg();
        end
        n = tick_q.size();
        if ($urandom_range(4) == 0) begin
          push_noise($urandom_range(5, 40));
        end else begin
          push_settle($urandom_range(6), 1'($urandom), $urandom_range(40, 160));
        end
        phase_ticks += tick_q.size() - n;
        while (tick_q.size() != 0) @(posedge clk);
        seg++;
      end
    end

    while (tick_q.size() != 0 || in_valid || lid_reports_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/lsd_pkg.sv
design/lsd_window.sv
design/lid_switch_sample_debouncer_core.sv
verif/tb_lid_switch_sample_debouncer_core.sv
